@@ rtl/core/gfalu_pkg.sv @@
// ----------------------------------------------------------------------------
// gfalu_pkg: shared definitions for the GF(2^256) field ALU
// Field geometry, reduction constant, transaction structs, mode codes and the
// inversion addition chain.
// ----------------------------------------------------------------------------
package gfalu_pkg;

  localparam int unsigned FieldBits = 256;
  localparam int unsigned WordBits  = 64;

  // Bits of the multiplier operand consumed per cycle.
  localparam int unsigned DigitBits = 4;
  localparam int unsigned NumDigits = FieldBits / DigitBits;
  localparam int unsigned DigitCntW = $clog2(NumDigits);

  // Low part of x^256 + x^10 + x^5 + x^2 + 1.
  localparam logic [FieldBits-1:0] PolyLow = FieldBits'(12'h425);

  // Squaring runs of the inversion chain.
  localparam int unsigned SqrRun15  = 15;
  localparam int unsigned SqrRun30  = 30;
  localparam int unsigned SqrRun60  = 60;
  localparam int unsigned SqrRun120 = 120;

  localparam int unsigned ChainSteps = 11;
  localparam int unsigned StepW      = $clog2(ChainSteps);
  localparam int unsigned SqCntW     = $clog2(SqrRun120 + 1);
  localparam logic [StepW-1:0] LastStep = StepW'(ChainSteps - 1);

  typedef logic [FieldBits-1:0] felem_t;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_MUL = 2'd1,
    MODE_SQR = 2'd2,
    MODE_INV = 2'd3
  } mode_e;

  // Operand registers that can feed the multiplier's second input.
  typedef enum logic [1:0] {
    SEL_A,
    SEL_E2,
    SEL_E3,
    SEL_T
  } ysel_e;

  typedef enum logic [1:0] {
    DST_E2,
    DST_E3,
    DST_T
  } dest_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  typedef struct packed {
    mode_e               mode;
    logic [WordBits-1:0] a_word3;
    logic [WordBits-1:0] a_word2;
    logic [WordBits-1:0] a_word1;
    logic [WordBits-1:0] a_word0;
    logic [WordBits-1:0] b_word3;
    logic [WordBits-1:0] b_word2;
    logic [WordBits-1:0] b_word1;
    logic [WordBits-1:0] b_word0;
  } gfalu_in_t;

  typedef struct packed {
    logic [WordBits-1:0] result_word3;
    logic [WordBits-1:0] result_word2;
    logic [WordBits-1:0] result_word1;
    logic [WordBits-1:0] result_word0;
  } gfalu_out_t;

  typedef struct packed {
    logic [SqCntW-1:0] sq_n;
    ysel_e             ysel;
    dest_e             dest;
  } chain_step_t;

  // One chain step: square the running value sq_n times, multiply by ysel,
  // store in dest. The running value always continues into the next step.
  function automatic chain_step_t chain_step(logic [StepW-1:0] idx);
    chain_step_t s;
    case (idx)
      4'd0:    s = '{SqCntW'(1),         SEL_A,  DST_E2};
      4'd1:    s = '{SqCntW'(1),         SEL_A,  DST_E3};
      4'd2:    s = '{SqCntW'(2),         SEL_E2, DST_E2};
      4'd3:    s = '{SqCntW'(5),         SEL_E2, DST_T};
      4'd4:    s = '{SqCntW'(5),         SEL_E2, DST_E3};
      4'd5:    s = '{SqCntW'(SqrRun15),  SEL_E3, DST_T};
      4'd6:    s = '{SqCntW'(SqrRun30),  SEL_T,  DST_T};
      4'd7:    s = '{SqCntW'(SqrRun60),  SEL_T,  DST_T};
      4'd8:    s = '{SqCntW'(SqrRun120), SEL_T,  DST_T};
      4'd9:    s = '{SqCntW'(SqrRun15),  SEL_E3, DST_T};
      default: s = '{SqCntW'(0),         SEL_T,  DST_T};
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/gfalu_mul.sv @@
// ----------------------------------------------------------------------------
// gfalu_mul: digit-serial GF(2^256) multiplier
// Interleaved MSB-first multiply and reduce, DigitBits bits of y per cycle.
// ----------------------------------------------------------------------------
module gfalu_mul import gfalu_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  felem_t x_i,
  input  felem_t y_i,
  output logic   done_o,
  output felem_t p_o
);

  felem_t               acc_q, acc_d;
  felem_t               x_q;
  felem_t               y_q;
  logic [DigitCntW-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;

  // Shift by x with reduction, then add x where the digit bit is set.
  function automatic felem_t mul_digit(felem_t acc, felem_t x, logic [DigitBits-1:0] dig);
    felem_t r;
    logic   msb;
    r = acc;
    for (int k = DigitBits - 1; k >= 0; k--) begin
      msb = r[FieldBits-1];
      r   = {r[FieldBits-2:0], 1'b0};
      if (msb) r = r ^ PolyLow;
      if (dig[k]) r = r ^ x;
    end
    return r;
  endfunction

  assign acc_d = mul_digit(acc_q, x_q, y_q[FieldBits-1 -: DigitBits]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + DigitCntW'(1);
        if (cnt_q == DigitCntW'(NumDigits - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      y_q   <= y_i;
    end else if (run_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[FieldBits-DigitBits-1:0], {DigitBits{1'b0}}};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

@@ rtl/core/gf256_field_alu.sv @@
// ----------------------------------------------------------------------------
// gf256_field_alu: GF(2^256) add, multiply, square and invert
// Sequencer and operand registers around one digit-serial field multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                        Transfer
//  command   start, busy, op_i            start high and busy low at clk edge
//  result    result_valid_o, result_o     one-cycle strobe, no back-pressure
//
//  Add: result strobe in the cycle after the command; busy stays low.
//  Multiply and square: one pass of the digit-serial multiplier over 64 digits
//  of 4 bits, with an issue state before it and a done strobe after it.
//  Invert: 254 squarings and 11 multiplications in a fixed chain, 265 passes.
//  Zero inverts to zero.
//  Reset clears the sequencer and strobes only; busy is low right after reset.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
module gf256_field_alu import gfalu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  gfalu_in_t  op_i,
  output logic       result_valid_o,
  output gfalu_out_t result_o
);

  state_e            state_q, state_d;
  mode_e             mode_q;
  logic [StepW-1:0]  step_q;
  logic [SqCntW-1:0] sq_cnt_q;
  felem_t            a_q, e2_q, e3_q, t_q, s_q, res_q;
  logic              valid_q;

  logic        accept;
  logic        mul_start;
  logic        mul_done;
  felem_t      mul_y;
  felem_t      mul_p;
  felem_t      op_a, op_b;
  chain_step_t first_step;
  chain_step_t cur_step;
  chain_step_t next_step;
  ysel_e       ysel;
  logic        last_step;

  assign op_a   = {op_i.a_word3, op_i.a_word2, op_i.a_word1, op_i.a_word0};
  assign op_b   = {op_i.b_word3, op_i.b_word2, op_i.b_word1, op_i.b_word0};
  assign accept = start && !busy;

  assign first_step = chain_step(StepW'(0));
  assign cur_step   = chain_step(step_q);
  assign next_step  = chain_step(step_q + StepW'(1));
  assign last_step  = (mode_q != MODE_INV) || (step_q == LastStep);

  // Operand b of a multiply is kept in the E_2 register, which the inversion
  // chain needs only for its own items.
  always_comb begin
    if (mode_q == MODE_INV) ysel = cur_step.ysel;
    else if (mode_q == MODE_MUL) ysel = SEL_E2;
    else ysel = SEL_A;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && op_i.mode != MODE_ADD) state_d = ST_ISSUE;
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          if (sq_cnt_q == '0 && last_step) state_d = ST_IDLE;
          else state_d = ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    mul_start = 1'b0;
    mul_y     = s_q;
    busy      = 1'b1;
    case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_ISSUE: begin
        mul_start = 1'b1;
        if (sq_cnt_q == '0) begin
          case (ysel)
            SEL_A:   mul_y = a_q;
            SEL_E2:  mul_y = e2_q;
            SEL_E3:  mul_y = e3_q;
            default: mul_y = t_q;
          endcase
        end
      end
      default: ;
    endcase
  end

  gfalu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (s_q),
    .y_i     (mul_y),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= 1'b0;
      mode_q   <= MODE_ADD;
      step_q   <= '0;
      sq_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      if (accept) begin
        mode_q   <= op_i.mode;
        step_q   <= '0;
        sq_cnt_q <= (op_i.mode == MODE_INV) ? first_step.sq_n : '0;
        if (op_i.mode == MODE_ADD) valid_q <= 1'b1;
      end else if (state_q == ST_WAIT && mul_done) begin
        if (sq_cnt_q != '0) begin
          sq_cnt_q <= sq_cnt_q - SqCntW'(1);
        end else if (last_step) begin
          valid_q <= 1'b1;
        end else begin
          step_q   <= step_q + StepW'(1);
          sq_cnt_q <= next_step.sq_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q   <= op_a;
      e2_q  <= op_b;
      s_q   <= op_a;
      res_q <= op_a ^ op_b;
    end else if (state_q == ST_WAIT && mul_done) begin
      s_q <= mul_p;
      if (sq_cnt_q == '0) begin
        if (last_step) begin
          res_q <= mul_p;
        end else begin
          case (cur_step.dest)
            DST_E2:  e2_q <= mul_p;
            DST_E3:  e3_q <= mul_p;
            default: t_q  <= mul_p;
          endcase
        end
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = gfalu_out_t'(res_q);

  // The multiplier only finishes a pass that the sequencer is waiting for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_WAIT)
    else $error("multiplier done outside of wait state");

  // Plain multiply and square never run squaring passes or chain steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && mode_q != MODE_INV) |-> (sq_cnt_q == '0 && step_q == '0))
    else $error("chain counters moved for a non-invert transaction");

  // The final pass of a transaction produces exactly one result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && mul_done && sq_cnt_q == '0 && last_step)
      |=> (result_valid_o && !busy))
    else $error("final pass did not deliver a result");

  // The step counter stays within the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> step_q <= LastStep)
    else $error("chain step out of range");

endmodule

@@ tb/gf256_field_alu_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf256_field_alu_tb: self-checking bench for the GF(2^256) field ALU
// Drives add, multiply, square and invert commands through the start/busy
// handshake and compares every result strobe with a bit-exact software model
// of the field arithmetic (x^256 + x^10 + x^5 + x^2 + 1). A directed set
// covers the corner operands; random commands follow, gapped then back to back.
// ----------------------------------------------------------------------------
module gf256_field_alu_tb import gfalu_pkg::*; ();

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cmd_start = 1'b0;
  gfalu_in_t  cmd_op = '0;
  logic       alu_busy;
  logic       res_valid;
  gfalu_out_t res;

  gfalu_in_t  pending_q[$];
  gfalu_out_t result_q[$];

  int         mode_count[4];
  int         checked = 0;
  int         errors = 0;
  int         gap_left = 0;
  int         cycle_budget = 0;
  int         cycles = 0;
  bit         sender_idling = 1'b1;
  bit         accepted;
  gfalu_out_t want;

  gf256_field_alu u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (cmd_start),
    .busy           (alu_busy),
    .op_i           (cmd_op),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Carry-less product followed by two folds of everything above bit 255.
  function automatic felem_t gf_mul(felem_t x, felem_t y);
    logic [2*FieldBits-1:0] prod;
    logic [2*FieldBits-1:0] fold;
    prod = '0;
    for (int i = 0; i < FieldBits; i++) begin
      if (y[i]) prod ^= {{FieldBits{1'b0}}, x} << i;
    end
    repeat (2) begin
      fold = {{FieldBits{1'b0}}, prod[2*FieldBits-1:FieldBits]};
      prod = {{FieldBits{1'b0}}, prod[FieldBits-1:0]};
      for (int k = 0; k < 12; k++) begin
        if (PolyLow[k]) prod ^= fold << k;
      end
    end
    return prod[FieldBits-1:0];
  endfunction

  // Returns x^(2^n) * y.
  function automatic felem_t gf_sqr_run_mul(felem_t x, int unsigned n, felem_t y);
    felem_t s;
    s = x;
    repeat (n) s = gf_mul(s, s);
    return gf_mul(s, y);
  endfunction

  // a^(2^256 - 2) along the chain a^(2^k - 1) for k = 2, 3, 5, 10, 15, ..., 255.
  function automatic felem_t gf_inverse(felem_t a);
    felem_t e2;
    felem_t e3;
    felem_t t;
    e2 = gf_sqr_run_mul(a, 1, a);
    e3 = gf_sqr_run_mul(e2, 1, a);
    e2 = gf_sqr_run_mul(e3, 2, e2);
    t  = gf_sqr_run_mul(e2, 5, e2);
    e3 = gf_sqr_run_mul(t, 5, e2);
    t  = gf_sqr_run_mul(e3, SqrRun15, e3);
    t  = gf_sqr_run_mul(t, SqrRun30, t);
    t  = gf_sqr_run_mul(t, SqrRun60, t);
    t  = gf_sqr_run_mul(t, SqrRun120, t);
    t  = gf_sqr_run_mul(t, SqrRun15, e3);
    return gf_mul(t, t);
  endfunction

  function automatic gfalu_out_t gf_compute(gfalu_in_t c);
    felem_t     a;
    felem_t     b;
    felem_t     r;
    gfalu_out_t o;
    a = {c.a_word3, c.a_word2, c.a_word1, c.a_word0};
    b = {c.b_word3, c.b_word2, c.b_word1, c.b_word0};
    case (c.mode)
      MODE_ADD: r = a ^ b;
      MODE_MUL: r = gf_mul(a, b);
      MODE_SQR: r = gf_mul(a, a);
      default:  r = gf_inverse(a);
    endcase
    o.result_word0 = r[63:0];
    o.result_word1 = r[127:64];
    o.result_word2 = r[191:128];
    o.result_word3 = r[255:192];
    return o;
  endfunction

  // Mostly dense random elements, with zero, one, all ones and sparse patterns.
  function automatic felem_t rand_elem();
    felem_t v;
    for (int w = 0; w < FieldBits / 32; w++) v[w*32 +: 32] = $urandom();
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = felem_t'(1);
      2: v = '1;
      3: begin
        v = '0;
        v[$urandom_range(0, FieldBits - 1)] = 1'b1;
      end
      4: v[FieldBits-1] = 1'b1;
      5: v[FieldBits-1:WordBits] = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_cmd(mode_e m, felem_t a, felem_t b);
    gfalu_in_t c;
    c.mode    = m;
    c.a_word0 = a[63:0];
    c.a_word1 = a[127:64];
    c.a_word2 = a[191:128];
    c.a_word3 = a[255:192];
    c.b_word0 = b[63:0];
    c.b_word1 = b[127:64];
    c.b_word2 = b[191:128];
    c.b_word3 = b[255:192];
    // Worst case per transaction: the block's own cycles plus the longest gap.
    cycle_budget += (m == MODE_INV) ? 17520 : 90;
    pending_q.push_back(c);
  endtask

  task automatic queue_random(int n);
    mode_e m;
    int    pick;
    repeat (n) begin
      // Inversions are kept rare since each one is a long chain of multiplier passes.
      pick = $urandom_range(0, 199);
      if (pick < 3)        m = MODE_INV;
      else if (pick < 63)  m = MODE_ADD;
      else if (pick < 143) m = MODE_MUL;
      else                 m = MODE_SQR;
      queue_cmd(m, rand_elem(), rand_elem());
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || cmd_start || result_q.size() != 0) @(posedge clk);
  endtask

  // Command driver: holds an item until start meets busy low, then loads the next.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cmd_start <= 1'b0;
      cmd_op    <= '0;
      gap_left  = 0;
    end else begin
      accepted = cmd_start && !alu_busy;
      if (accepted) begin
        result_q.push_back(gf_compute(cmd_op));
        mode_count[cmd_op.mode]++;
      end
      if (!cmd_start || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_start <= 1'b0;
        end else if (accepted && sender_idling && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 18) - 1;
          cmd_start <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cmd_start <= 1'b1;
          cmd_op    <= pending_q.pop_front();
        end else begin
          cmd_start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every strobe must match the oldest outstanding transaction.
  always @(posedge clk) begin
    if (rst_n && res_valid) begin
      if (result_q.size() == 0) begin
        errors++;
        $error("unexpected result strobe, result_word0 = %h", res.result_word0);
      end else begin
        want = result_q.pop_front();
        checked++;
        if (res.result_word0 !== want.result_word0) begin
          errors++;
          $error("result_word0: expected %h, got %h",
                 want.result_word0, res.result_word0);
        end
        if (res.result_word1 !== want.result_word1) begin
          errors++;
          $error("result_word1: expected %h, got %h",
                 want.result_word1, res.result_word1);
        end
        if (res.result_word2 !== want.result_word2) begin
          errors++;
          $error("result_word2: expected %h, got %h",
                 want.result_word2, res.result_word2);
        end
        if (res.result_word3 !== want.result_word3) begin
          errors++;
          $error("result_word3: expected %h, got %h",
                 want.result_word3, res.result_word3);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 4 * cycle_budget + 20000) begin
      $display("** gf256_field_alu: FAILED **");
      $finish;
    end
  end

  initial begin
    felem_t one;
    felem_t ones;
    felem_t top;
    felem_t r1;
    felem_t r2;
    one  = felem_t'(1);
    ones = '1;
    top  = one << (FieldBits - 1);
    r1   = rand_elem();
    r2   = rand_elem();
    for (int w = 0; w < FieldBits / 32; w++) r1[w*32 +: 32] = $urandom();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_cmd(MODE_ADD, '0, '0);
    queue_cmd(MODE_ADD, ones, ones);
    queue_cmd(MODE_ADD, ones, r1);
    queue_cmd(MODE_ADD, r1, r2);
    queue_cmd(MODE_MUL, '0, r1);
    queue_cmd(MODE_MUL, one, r1);
    queue_cmd(MODE_MUL, ones, ones);
    // Top-bit products exercise both reduction folds.
    queue_cmd(MODE_MUL, top, top);
    queue_cmd(MODE_MUL, top, one << 1);
    queue_cmd(MODE_MUL, one << 128, one << 128);
    queue_cmd(MODE_MUL, r1, r2);
    queue_cmd(MODE_SQR, ones, '0);
    queue_cmd(MODE_SQR, top, ones);
    queue_cmd(MODE_SQR, r1, r2);
    queue_cmd(MODE_SQR, '0, ones);
    // Zero has no inverse; the chain must give zero.
    queue_cmd(MODE_INV, '0, ones);
    queue_cmd(MODE_INV, one, '0);
    queue_cmd(MODE_INV, one << 1, r2);
    queue_cmd(MODE_INV, ones, ones);
    queue_cmd(MODE_INV, r1, '0);
    wait_drained();

    queue_random(1020);
    // Sender holds off here until every outstanding result is back.
    wait_drained();

    sender_idling <= 1'b0;
    queue_random(430);
    wait_drained();
    repeat (100) @(posedge clk);

    $display("Ran %0d add, %0d multiply, %0d square and %0d invert transactions;",
             mode_count[MODE_ADD], mode_count[MODE_MUL], mode_count[MODE_SQR],
             mode_count[MODE_INV]);
    $display("%0d results compared, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("** gf256_field_alu: PASSED **");
    end else begin
      $display("** gf256_field_alu: FAILED **");
    end
    $finish;
  end

endmodule
